// File: src/rpwm_pkg.sv
// rpwm_pkg: shared types, codes and constants of the ramped pwm block
// used by every module under src; depends on nothing
`default_nettype none
package rpwm_pkg;

  localparam int REACH_COUNT_DEF = 3;
  localparam int DIV_STEPS       = 33;
  localparam logic [32:0] PERIOD_NUM = 33'd1000;
  localparam logic [16:0] DUTY_ONE   = 17'd65536;

  typedef enum logic [1:0] {
    OPC_START  = 2'd0,
    OPC_TICK   = 2'd1,
    OPC_STOP   = 2'd2,
    OPC_FINISH = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_MOVING = 2'd1,
    MODE_DONE   = 2'd2
  } run_mode_t;

  typedef enum logic [2:0] {
    REG_TARGET_DUTY = 3'd0,
    REG_PWM_FREQ    = 3'd1,
    REG_RAMP_UP     = 3'd2,
    REG_RAMP_DOWN   = 3'd3,
    REG_STOP_MODE   = 3'd4,
    REG_SENSOR_TGT  = 3'd5,
    REG_STOP_GAP    = 3'd6,
    REG_CURVE       = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    EV_BETWEEN,
    EV_RAMPUP,
    EV_HOLD,
    EV_RAMPDN,
    EV_END
  } eval_case_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_START,
    DP_ABORT,
    DP_PERIOD,
    DP_OFFSET,
    DP_TICK,
    DP_HOLD,
    DP_FINISH,
    DP_BETWEEN,
    DP_END,
    DP_RUMUL,
    DP_RUDIV,
    DP_RDMUL,
    DP_RDDIV,
    DP_HOLDD,
    DP_DUTYQ,
    DP_GAP,
    DP_AMUL,
    DP_ADIV,
    DP_COMMIT,
    DP_OFFSET2,
    DP_PUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_PDIV,
    C_OFFMUL,
    C_EVAL,
    C_RUDIVS,
    C_RDDIVS,
    C_DWAIT1,
    C_APPR,
    C_ADIVS,
    C_DWAIT2,
    C_COMMIT,
    C_OFF2,
    C_PUSH
  } ctl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   latch;
  } cmd_t;

  typedef struct packed {
    opcode_t    opcode;
    logic       moving;
    logic       tgt_over;
    eval_case_t ecase;
    logic       appr;
    logic       in_gap;
    logic       div_done;
  } sts_t;

endpackage
`default_nettype wire

// File: src/rpwm_div.sv
// rpwm_div: restoring divider, one quotient bit per cycle
// depends on rpwm_pkg for the step count
`default_nettype none
module rpwm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [32:0]      quot
);

  logic [15:0] dvs;
  logic [15:0] rem;
  logic [5:0]  count;
  logic        busy;
  logic [16:0] rem_sh;
  logic        fit;

  always_comb begin
    rem_sh = {rem, quot[32]};
    fit    = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'(rpwm_pkg::DIV_STEPS);
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fit ? 16'(rem_sh - {1'b0, dvs}) : rem_sh[15:0];
      quot <= {quot[31:0], fit};
    end
  end

endmodule
`default_nettype wire

// File: src/rpwm_dp.sv
// rpwm_dp: configuration registers, run state, shared multiplier and divider
// depends on rpwm_pkg and rpwm_div; driven by rpwm_ctl commands
`default_nettype none
module rpwm_dp #(
  parameter int REACH_COUNT = rpwm_pkg::REACH_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rpwm_pkg::cmd_t cmd,
  output rpwm_pkg::sts_t     sts,
  input  wire logic [1:0]    opcode,
  input  wire logic [9:0]    sensor_sample,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [16:0]   cfg_data,
  output logic               drive_on,
  output logic [1:0]         run_state,
  output logic [16:0]        duty_level,
  output logic [3:0]         reach_hits
);

  logic [16:0] target_duty;
  logic [9:0]  pwm_frequency_hz;
  logic [15:0] ramp_up_ms;
  logic [15:0] ramp_down_ms;
  logic [1:0]  stop_mode;
  logic [9:0]  sensor_target;
  logic signed [10:0] stop_gap;
  logic [9:0]  approach_curve;

  rpwm_pkg::run_mode_t run_mode;
  logic [31:0] elapsed_ms, next_on_ms, off_at_ms, hold_end_ms;
  logic [9:0]  period_ms;
  logic        switch_active;
  logic [16:0] duty_now;
  logic [3:0]  hit_count;
  logic [9:0]  sample;
  logic [16:0] duty;
  logic [32:0] mul_p;

  logic [15:0] down;
  logic [31:0] e;
  logic signed [11:0] rel, gap_x, d;
  logic [11:0] dsum;
  logic [3:0]  hit_inc;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic        mul_en;
  logic        div_start;
  logic [32:0] div_dvd;
  logic [15:0] div_dvs;
  logic        div_done;
  logic [32:0] div_quot;
  logic [9:0]  fsel;
  rpwm_pkg::eval_case_t ecase;

  rpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    down  = (ramp_down_ms != 16'd0) ? ramp_down_ms : ramp_up_ms;
    e     = elapsed_ms - hold_end_ms;
    fsel  = (pwm_frequency_hz != 10'd0) ? pwm_frequency_hz : 10'd1;
    if (elapsed_ms < next_on_ms)                 ecase = rpwm_pkg::EV_BETWEEN;
    else if (elapsed_ms < {16'd0, ramp_up_ms})   ecase = rpwm_pkg::EV_RAMPUP;
    else if (elapsed_ms < hold_end_ms)           ecase = rpwm_pkg::EV_HOLD;
    else if (e < {16'd0, down})                  ecase = rpwm_pkg::EV_RAMPDN;
    else                                         ecase = rpwm_pkg::EV_END;
    rel   = stop_mode[1] ? signed'({2'b00, sensor_target} - {2'b00, sample})
                         : signed'({2'b00, sample} - {2'b00, sensor_target});
    gap_x = 12'(stop_gap);
    d     = rel - gap_x;
    dsum  = 12'(d) + {2'b00, approach_curve};
    hit_inc = (hit_count != 4'd15) ? hit_count + 4'd1 : hit_count;

    sts.opcode   = rpwm_pkg::opcode_t'(opcode);
    sts.moving   = run_mode == rpwm_pkg::MODE_MOVING;
    sts.tgt_over = target_duty > rpwm_pkg::DUTY_ONE;
    sts.ecase    = ecase;
    sts.appr     = stop_mode != 2'd0;
    sts.in_gap   = rel <= gap_x;
    sts.div_done = div_done;

    mul_en = 1'b1;
    mul_a  = target_duty;
    mul_b  = '0;
    case (cmd.op)
      rpwm_pkg::DP_PERIOD: mul_b = {6'd0, div_quot[9:0]};
      rpwm_pkg::DP_RUMUL:  mul_b = elapsed_ms[15:0];
      rpwm_pkg::DP_RDMUL:  mul_b = down - e[15:0];
      rpwm_pkg::DP_AMUL: begin
        mul_a = duty;
        mul_b = {4'd0, 12'(d)};
      end
      rpwm_pkg::DP_COMMIT: begin
        mul_a = duty;
        mul_b = {6'd0, period_ms};
      end
      default: mul_en = 1'b0;
    endcase

    div_start = 1'b1;
    div_dvd   = mul_p;
    div_dvs   = ramp_up_ms;
    case (cmd.op)
      rpwm_pkg::DP_START: begin
        div_dvd = rpwm_pkg::PERIOD_NUM;
        div_dvs = {6'd0, fsel};
      end
      rpwm_pkg::DP_RUDIV: div_dvs = ramp_up_ms;
      rpwm_pkg::DP_RDDIV: div_dvs = down;
      rpwm_pkg::DP_ADIV:  div_dvs = {4'd0, dsum};
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) mul_p <= mul_a * mul_b;
    if (cmd.latch) sample <= sensor_sample;
    if (cmd.op == rpwm_pkg::DP_DUTYQ) duty <= div_quot[16:0];
    if (cmd.op == rpwm_pkg::DP_HOLDD) duty <= target_duty;
    if (cmd.op == rpwm_pkg::DP_PUSH) begin
      drive_on   <= switch_active;
      run_state  <= run_mode;
      duty_level <= duty_now;
      reach_hits <= hit_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_duty      <= '0;
      pwm_frequency_hz <= 10'd1;
      ramp_up_ms       <= 16'd1;
      ramp_down_ms     <= '0;
      stop_mode        <= '0;
      sensor_target    <= '0;
      stop_gap         <= '0;
      approach_curve   <= '0;
      run_mode         <= rpwm_pkg::MODE_IDLE;
      elapsed_ms       <= '0;
      next_on_ms       <= '0;
      off_at_ms        <= '0;
      hold_end_ms      <= '1;
      period_ms        <= '0;
      switch_active    <= 1'b0;
      duty_now         <= '0;
      hit_count        <= '0;
    end else begin
      if (cfg_we) begin
        case (rpwm_pkg::reg_index_t'(cfg_index))
          rpwm_pkg::REG_TARGET_DUTY: target_duty      <= cfg_data;
          rpwm_pkg::REG_PWM_FREQ:    pwm_frequency_hz <= cfg_data[9:0];
          rpwm_pkg::REG_RAMP_UP:     ramp_up_ms       <= cfg_data[15:0];
          rpwm_pkg::REG_RAMP_DOWN:   ramp_down_ms     <= cfg_data[15:0];
          rpwm_pkg::REG_STOP_MODE:   stop_mode        <= cfg_data[1:0];
          rpwm_pkg::REG_SENSOR_TGT:  sensor_target    <= cfg_data[9:0];
          rpwm_pkg::REG_STOP_GAP:    stop_gap         <= signed'(cfg_data[10:0]);
          rpwm_pkg::REG_CURVE:       approach_curve   <= cfg_data[9:0];
          default: ;
        endcase
      end
      case (cmd.op)
        rpwm_pkg::DP_START: begin
          elapsed_ms  <= '0;
          next_on_ms  <= '0;
          hold_end_ms <= '1;
          duty_now    <= '0;
          hit_count   <= '0;
        end
        rpwm_pkg::DP_ABORT: begin
          off_at_ms     <= '0;
          switch_active <= 1'b0;
          run_mode      <= rpwm_pkg::MODE_DONE;
        end
        rpwm_pkg::DP_PERIOD: begin
          period_ms <= div_quot[9:0];
          run_mode  <= rpwm_pkg::MODE_MOVING;
        end
        rpwm_pkg::DP_OFFSET: off_at_ms <= {15'd0, mul_p[32:16]};
        rpwm_pkg::DP_TICK: begin
          if (elapsed_ms != '1) elapsed_ms <= elapsed_ms + 32'd1;
        end
        rpwm_pkg::DP_HOLD: begin
          if (run_mode == rpwm_pkg::MODE_MOVING) hold_end_ms <= elapsed_ms;
        end
        rpwm_pkg::DP_FINISH: begin
          run_mode      <= rpwm_pkg::MODE_IDLE;
          switch_active <= 1'b0;
        end
        rpwm_pkg::DP_BETWEEN: begin
          if (elapsed_ms > off_at_ms) switch_active <= 1'b0;
        end
        rpwm_pkg::DP_END: begin
          switch_active <= 1'b0;
          run_mode      <= rpwm_pkg::MODE_DONE;
        end
        rpwm_pkg::DP_GAP: begin
          duty_now      <= '0;
          switch_active <= 1'b0;
          hit_count     <= hit_inc;
          if (hit_inc >= 4'(REACH_COUNT)) run_mode <= rpwm_pkg::MODE_DONE;
        end
        rpwm_pkg::DP_AMUL: hit_count <= '0;
        rpwm_pkg::DP_COMMIT: begin
          duty_now      <= duty;
          switch_active <= 1'b1;
        end
        rpwm_pkg::DP_OFFSET2: begin
          off_at_ms  <= next_on_ms + {15'd0, mul_p[32:16]};
          next_on_ms <= next_on_ms + {22'd0, period_ms};
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/rpwm_ctl.sv
// rpwm_ctl: sequencer that steps the datapath through one input beat
// depends on rpwm_pkg; owns the handshakes of both channels
`default_nettype none
module rpwm_ctl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire rpwm_pkg::sts_t sts,
  output rpwm_pkg::cmd_t      cmd
);

  rpwm_pkg::ctl_state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpwm_pkg::C_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = rpwm_pkg::DP_NONE;
    cmd.latch  = 1'b0;
    in_stall   = state != rpwm_pkg::C_IDLE;
    out_valid_next = out_valid && out_stall;
    case (state)
      rpwm_pkg::C_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = rpwm_pkg::C_PUSH;
          case (sts.opcode)
            rpwm_pkg::OPC_START: begin
              cmd.op     = rpwm_pkg::DP_START;
              state_next = rpwm_pkg::C_PDIV;
            end
            rpwm_pkg::OPC_TICK: begin
              if (sts.moving) begin
                cmd.op     = rpwm_pkg::DP_TICK;
                state_next = rpwm_pkg::C_EVAL;
              end
            end
            rpwm_pkg::OPC_STOP:   cmd.op = rpwm_pkg::DP_HOLD;
            rpwm_pkg::OPC_FINISH: cmd.op = rpwm_pkg::DP_FINISH;
            default: ;
          endcase
        end
      end
      rpwm_pkg::C_PDIV: begin
        if (sts.div_done) begin
          if (sts.tgt_over) begin
            cmd.op     = rpwm_pkg::DP_ABORT;
            state_next = rpwm_pkg::C_PUSH;
          end else begin
            cmd.op     = rpwm_pkg::DP_PERIOD;
            state_next = rpwm_pkg::C_OFFMUL;
          end
        end
      end
      rpwm_pkg::C_OFFMUL: begin
        cmd.op     = rpwm_pkg::DP_OFFSET;
        state_next = rpwm_pkg::C_EVAL;
      end
      rpwm_pkg::C_EVAL: begin
        case (sts.ecase)
          rpwm_pkg::EV_BETWEEN: begin
            cmd.op     = rpwm_pkg::DP_BETWEEN;
            state_next = rpwm_pkg::C_PUSH;
          end
          rpwm_pkg::EV_RAMPUP: begin
            cmd.op     = rpwm_pkg::DP_RUMUL;
            state_next = rpwm_pkg::C_RUDIVS;
          end
          rpwm_pkg::EV_HOLD: begin
            cmd.op     = rpwm_pkg::DP_HOLDD;
            state_next = rpwm_pkg::C_APPR;
          end
          rpwm_pkg::EV_RAMPDN: begin
            cmd.op     = rpwm_pkg::DP_RDMUL;
            state_next = rpwm_pkg::C_RDDIVS;
          end
          default: begin
            cmd.op     = rpwm_pkg::DP_END;
            state_next = rpwm_pkg::C_PUSH;
          end
        endcase
      end
      rpwm_pkg::C_RUDIVS: begin
        cmd.op     = rpwm_pkg::DP_RUDIV;
        state_next = rpwm_pkg::C_DWAIT1;
      end
      rpwm_pkg::C_RDDIVS: begin
        cmd.op     = rpwm_pkg::DP_RDDIV;
        state_next = rpwm_pkg::C_DWAIT1;
      end
      rpwm_pkg::C_DWAIT1: begin
        if (sts.div_done) begin
          cmd.op     = rpwm_pkg::DP_DUTYQ;
          state_next = rpwm_pkg::C_APPR;
        end
      end
      rpwm_pkg::C_APPR: begin
        if (!sts.appr) begin
          cmd.op     = rpwm_pkg::DP_COMMIT;
          state_next = rpwm_pkg::C_OFF2;
        end else if (sts.in_gap) begin
          cmd.op     = rpwm_pkg::DP_GAP;
          state_next = rpwm_pkg::C_PUSH;
        end else begin
          cmd.op     = rpwm_pkg::DP_AMUL;
          state_next = rpwm_pkg::C_ADIVS;
        end
      end
      rpwm_pkg::C_ADIVS: begin
        cmd.op     = rpwm_pkg::DP_ADIV;
        state_next = rpwm_pkg::C_DWAIT2;
      end
      rpwm_pkg::C_DWAIT2: begin
        if (sts.div_done) begin
          cmd.op     = rpwm_pkg::DP_DUTYQ;
          state_next = rpwm_pkg::C_COMMIT;
        end
      end
      rpwm_pkg::C_COMMIT: begin
        cmd.op     = rpwm_pkg::DP_COMMIT;
        state_next = rpwm_pkg::C_OFF2;
      end
      rpwm_pkg::C_OFF2: begin
        cmd.op     = rpwm_pkg::DP_OFFSET2;
        state_next = rpwm_pkg::C_PUSH;
      end
      rpwm_pkg::C_PUSH: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = rpwm_pkg::DP_PUSH;
          out_valid_next = 1'b1;
          state_next     = rpwm_pkg::C_IDLE;
        end
      end
      default: state_next = rpwm_pkg::C_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/ramped_pwm_with_sensor_stop.sv
// ramped_pwm_with_sensor_stop: top level joining sequencer and datapath
// depends on rpwm_pkg, rpwm_ctl, rpwm_dp and rpwm_div
//
// Ramped PWM controller driven by one beat per millisecond tick. Each input
// beat (start, tick, stop request, finish) yields one result beat with the
// drive state, run state, duty of the latest period and sensor hit count.
// One beat is worked on at a time; the result sits in an output register so
// a new beat can be taken while it waits. A boundary in a ramp runs the
// shared 33-step divider once, or twice in sensor-approach mode when the
// sensor is outside the stop gap; a start adds one more divide for the
// period. A stalled result keeps the next beat waiting.
`default_nettype none
module ramped_pwm_with_sensor_stop #(
  parameter int REACH_COUNT = rpwm_pkg::REACH_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [9:0]  sensor_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             drive_on,
  output logic [1:0]       run_state,
  output logic [16:0]      duty_level,
  output logic [3:0]       reach_hits,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  rpwm_pkg::cmd_t cmd;
  rpwm_pkg::sts_t sts;

  rpwm_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpwm_dp #(.REACH_COUNT(REACH_COUNT)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .sensor_sample (sensor_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .drive_on      (drive_on),
    .run_state     (run_state),
    .duty_level    (duty_level),
    .reach_hits    (reach_hits)
  );

endmodule
`default_nettype wire

// File: src/rpwm_chk.sv
// rpwm_chk: port-level checks of the ramped pwm block, bound to the top
// depends on rpwm_pkg and the top level's ports only
`default_nettype none
module rpwm_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        drive_on,
  input wire logic [1:0]  run_state,
  input wire logic [16:0] duty_level,
  input wire logic [3:0]  reach_hits
);

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive_on) && $stable(run_state)
      && $stable(duty_level) && $stable(reach_hits))
    else $error("stalled result beat changed");

  a_off_when_not_moving: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_state != rpwm_pkg::MODE_MOVING |-> !drive_on)
    else $error("drive on outside a run");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty_level <= rpwm_pkg::DUTY_ONE)
    else $error("duty above full scale");

endmodule

bind ramped_pwm_with_sensor_stop rpwm_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .drive_on   (drive_on),
  .run_state  (run_state),
  .duty_level (duty_level),
  .reach_hits (reach_hits)
);
`default_nettype wire

// File: tb/sv/tb_ramped_pwm_with_sensor_stop.sv
// tb_ramped_pwm_with_sensor_stop: self-checking testbench for the ramped pwm block
// predicts each result beat with a cycle-free model of runs, ramps and sensor stop
// depends on rpwm_pkg and ramped_pwm_with_sensor_stop
`timescale 1ns / 100ps
`default_nettype none
module tb_ramped_pwm_with_sensor_stop;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 150;

  typedef struct packed {
    logic        drive;
    logic [1:0]  state;
    logic [16:0] duty;
    logic [3:0]  hits;
  } pwm_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = rpwm_pkg::OPC_FINISH;
  logic [9:0]  sensor_sample = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        drive_on;
  logic [1:0]  run_state;
  logic [16:0] duty_level;
  logic [3:0]  reach_hits;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  ramped_pwm_with_sensor_stop dut (.*);

  // predictor copy of registers and run state
  logic [16:0] r_target;
  logic [9:0]  r_freq;
  logic [15:0] r_ramp_up, r_ramp_down;
  logic [1:0]  r_mode;
  logic [9:0]  r_sensor;
  int          r_gap;
  logic [9:0]  r_curve;
  rpwm_pkg::run_mode_t m_mode;
  logic [31:0] m_elapsed, m_next_on, m_off_at, m_hold_end;
  logic [9:0]  m_period;
  logic        m_switch;
  logic [16:0] m_duty;
  logic [3:0]  m_hits;

  pwm_result_t expected_beats[$];
  int src_idle_pct = 0, snk_idle_pct = 0;
  int mismatches = 0, beats_sent = 0, beats_checked = 0, stalled_cycles = 0;
  bit timed_out = 0;

  initial forever #6 clk = ~clk;

  always @(negedge clk) out_stall = ($urandom_range(99) < snk_idle_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    pwm_result_t got, exp_r;
    if (!rst && out_valid && !out_stall) begin
      got = '{drive_on, run_state, duty_level, reach_hits};
      beats_checked++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_r = expected_beats.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch beat %0d: expected drive %b state %0d duty %0d hits %0d,",
                      " got drive %b state %0d duty %0d hits %0d"},
                     beats_checked, exp_r.drive, exp_r.state, exp_r.duty, exp_r.hits,
                     got.drive, got.state, got.duty, got.hits);
        end
      end
    end
  end

  task automatic model_reset();
    r_target = 0; r_freq = 1; r_ramp_up = 1; r_ramp_down = 0; r_mode = 0;
    r_sensor = 0; r_gap = 0; r_curve = 0;
    m_mode = rpwm_pkg::MODE_IDLE; m_elapsed = 0; m_next_on = 0; m_off_at = 0;
    m_hold_end = '1; m_period = 0; m_switch = 0; m_duty = 0; m_hits = 0;
  endtask

  task automatic period_boundary(logic [9:0] smp);
    logic [31:0] t, e, down;
    logic [63:0] duty, d;
    int rel;
    t = m_elapsed;
    if (t < m_next_on) begin
      if (t > m_off_at) m_switch = 0;
      return;
    end
    if (t < 32'(r_ramp_up)) duty = (64'(r_target) * t) / r_ramp_up;
    else if (t < m_hold_end) duty = 64'(r_target);
    else begin
      e = t - m_hold_end;
      down = (r_ramp_down != 0) ? 32'(r_ramp_down) : 32'(r_ramp_up);
      if (e < down) duty = (64'(r_target) * (down - e)) / down;
      else begin
        m_switch = 0; m_mode = rpwm_pkg::MODE_DONE;
        return;
      end
    end
    if (r_mode != 0) begin
      rel = r_mode[1] ? (int'(r_sensor) - int'(smp)) : (int'(smp) - int'(r_sensor));
      if (rel <= r_gap) begin
        m_duty = 0; m_switch = 0;
        if (m_hits < 15) m_hits++;
        if (m_hits >= rpwm_pkg::REACH_COUNT_DEF) begin
          m_switch = 0; m_mode = rpwm_pkg::MODE_DONE;
        end
        return;
      end
      d = 64'(32'(rel - r_gap));
      duty = (duty * d) / (d + 64'(r_curve));
      m_hits = 0;
    end
    m_duty = duty[16:0];
    m_switch = 1;
    m_off_at = m_next_on + 32'((64'(m_period) * m_duty) >> 16);
    m_next_on = m_next_on + 32'(m_period);
  endtask

  task automatic predict_pwm(rpwm_pkg::opcode_t op, logic [9:0] smp);
    logic [9:0] f;
    case (op)
      rpwm_pkg::OPC_START: begin
        f = (r_freq != 0) ? r_freq : 10'd1;
        m_period = 10'(1000 / f);
        m_elapsed = 0; m_next_on = 0; m_hold_end = '1; m_duty = 0; m_hits = 0;
        if (r_target > rpwm_pkg::DUTY_ONE) begin
          m_off_at = 0; m_switch = 0; m_mode = rpwm_pkg::MODE_DONE;
        end else begin
          m_mode = rpwm_pkg::MODE_MOVING;
          m_off_at = 32'((64'(r_target) * m_period) >> 16);
          period_boundary(smp);
        end
      end
      rpwm_pkg::OPC_TICK: if (m_mode == rpwm_pkg::MODE_MOVING) begin
        if (m_elapsed != '1) m_elapsed++;
        period_boundary(smp);
      end
      rpwm_pkg::OPC_STOP: if (m_mode == rpwm_pkg::MODE_MOVING) m_hold_end = m_elapsed;
      default: begin
        m_mode = rpwm_pkg::MODE_IDLE; m_switch = 0;
      end
    endcase
    expected_beats.push_back('{m_switch, m_mode, m_duty, m_hits});
  endtask

  task automatic send_beat(rpwm_pkg::opcode_t op, logic [9:0] smp);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1; opcode = op; sensor_sample = smp;
    do @(posedge clk); while (in_stall);
    predict_pwm(op, smp);
    beats_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(rpwm_pkg::reg_index_t idx, logic [16:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      rpwm_pkg::REG_TARGET_DUTY: r_target = val;
      rpwm_pkg::REG_PWM_FREQ:    r_freq = val[9:0];
      rpwm_pkg::REG_RAMP_UP:     r_ramp_up = val[15:0];
      rpwm_pkg::REG_RAMP_DOWN:   r_ramp_down = val[15:0];
      rpwm_pkg::REG_STOP_MODE:   r_mode = val[1:0];
      rpwm_pkg::REG_SENSOR_TGT:  r_sensor = val[9:0];
      rpwm_pkg::REG_STOP_GAP:
        r_gap = val[10] ? int'(val[10:0]) - 2048 : int'(val[10:0]);
      default:                   r_curve = val[9:0];
    endcase
  endtask

  task automatic set_config(logic [16:0] tgt, logic [9:0] freq, logic [15:0] up,
                            logic [15:0] dn, logic [1:0] mode, logic [9:0] sens,
                            logic [10:0] gap, logic [9:0] curve);
    wait_quiet();
    write_reg(rpwm_pkg::REG_TARGET_DUTY, tgt);
    write_reg(rpwm_pkg::REG_PWM_FREQ, 17'(freq));
    write_reg(rpwm_pkg::REG_RAMP_UP, 17'(up));
    write_reg(rpwm_pkg::REG_RAMP_DOWN, 17'(dn));
    write_reg(rpwm_pkg::REG_STOP_MODE, 17'(mode));
    write_reg(rpwm_pkg::REG_SENSOR_TGT, 17'(sens));
    write_reg(rpwm_pkg::REG_STOP_GAP, 17'(gap));
    write_reg(rpwm_pkg::REG_CURVE, 17'(curve));
  endtask

  function automatic logic [9:0] rand_sample();
    return 10'($urandom_range(1023));
  endfunction

  // one run: start, ticks mixed with random stop requests and opcodes, an optional finish
  task automatic drive_run(int n_ticks, bit near_target);
    logic [9:0] smp;
    send_beat(rpwm_pkg::OPC_START, rand_sample());
    for (int i = 0; i < n_ticks; i++) begin
      if (near_target)
        smp = 10'(int'(r_sensor) + $urandom_range(40) - 20);
      else
        smp = rand_sample();
      case ($urandom_range(29))
        0:       send_beat(rpwm_pkg::OPC_STOP, smp);
        1:       send_beat(rpwm_pkg::opcode_t'($urandom_range(3)), smp);
        default: send_beat(rpwm_pkg::OPC_TICK, smp);
      endcase
      if (i == n_ticks / 2 && $urandom_range(1))
        send_beat(rpwm_pkg::OPC_STOP, rand_sample());
    end
    if ($urandom_range(3) == 0) send_beat(rpwm_pkg::OPC_FINISH, rand_sample());
  endtask

  task automatic test_directed();
    set_config(17'd65536, 10'd100, 16'd4, 16'd0, 2'd0, 10'd0, 11'd0, 10'd0);
    send_beat(rpwm_pkg::OPC_TICK, 10'd0);
    send_beat(rpwm_pkg::OPC_STOP, 10'd1023);
    send_beat(rpwm_pkg::OPC_START, 10'd1023);
    repeat (6) send_beat(rpwm_pkg::OPC_TICK, 10'd0);
    send_beat(rpwm_pkg::OPC_STOP, 10'd0);
    repeat (6) send_beat(rpwm_pkg::OPC_TICK, 10'd1023);
    send_beat(rpwm_pkg::OPC_FINISH, 10'd0);
    set_config(17'd131071, 10'd0, 16'd0, 16'd65535, 2'd3, 10'd1023, 11'h400, 10'd1023);
    send_beat(rpwm_pkg::OPC_START, 10'd512);
    send_beat(rpwm_pkg::OPC_TICK, 10'd512);
    set_config(17'd40000, 10'd1023, 16'd0, 16'd2, 2'd1, 10'd500, 11'd5, 10'd1023);
    send_beat(rpwm_pkg::OPC_START, 10'd900);
    send_beat(rpwm_pkg::OPC_TICK, 10'd502);
    send_beat(rpwm_pkg::OPC_START, 10'd700);
    repeat (4) send_beat(rpwm_pkg::OPC_TICK, 10'd503);
    set_config(17'd65535, 10'd1, 16'd65535, 16'd1, 2'd2, 10'd0, 11'h3FF, 10'd0);
    send_beat(rpwm_pkg::OPC_START, 10'd0);
    send_beat(rpwm_pkg::OPC_TICK, 10'd1023);
  endtask

  task automatic test_random_runs(int n_items, bit approach);
    int start_count;
    logic [10:0] gap;
    start_count = beats_sent;
    while (beats_sent - start_count < n_items) begin
      gap = approach ? 11'($urandom_range(40) - 20) : 11'($urandom_range(2047));
      set_config(($urandom_range(9) == 0) ? 17'($urandom_range(131071))
                                           : 17'($urandom_range(65536)),
                 ($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                          : 10'($urandom_range(250)),
                 ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                          : 16'($urandom_range(12)),
                 ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                          : 16'($urandom_range(12)),
                 approach ? 2'($urandom_range(1, 3)) : 2'd0,
                 10'($urandom_range(20, 1000)), gap, 10'($urandom_range(1023)));
      repeat ($urandom_range(1, 3)) drive_run($urandom_range(5, 40), approach);
    end
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    src_idle_pct = 29; snk_idle_pct = 69;
    test_directed();
    test_random_runs(250, 0);
    test_random_runs(300, 1);
    src_idle_pct = 69; snk_idle_pct = 29;
    test_random_runs(300, 0);
    test_random_runs(300, 1);
    src_idle_pct = 0; snk_idle_pct = 0;
    test_random_runs(300, 0);
    test_random_runs(300, 1);
    wait_quiet();
    $display("covered %0d input beats over time-only and sensor-approach runs,", beats_sent);
    $display("%0d result beats compared, %0d differences", beats_checked, mismatches);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
src/rpwm_pkg.sv
src/rpwm_div.sv
src/rpwm_dp.sv
src/rpwm_ctl.sv
src/ramped_pwm_with_sensor_stop.sv
src/rpwm_chk.sv
tb/sv/tb_ramped_pwm_with_sensor_stop.sv
